[hdl/lwg_pkg.sv]
package lwg_pkg;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_LOAD,
    CFG_DIV,
    CFG_SIZE,
    CFG_MUL
  } cfg_state_t;

  localparam logic [2:0] REG_START_X       = 3'd0;
  localparam logic [2:0] REG_START_Y       = 3'd1;
  localparam logic [2:0] REG_END_X         = 3'd2;
  localparam logic [2:0] REG_END_Y         = 3'd3;
  localparam logic [2:0] REG_LANE_WIDTH    = 3'd4;
  localparam logic [2:0] REG_POINT_SPACING = 3'd5;

  typedef struct packed {
    logic flip;
    logic x_up;
    logic y_up;
    logic na_one;
    logic nl_one;
  } geo_flags_t;

endpackage

[hdl/lwg_div.sv]
module lwg_div #(
  parameter int REM_BITS = 25,
  parameter int Q_BITS   = 24,
  parameter int TAG_BITS = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [REM_BITS-1:0] rem_init,
  input  logic [Q_BITS-1:0]   num,
  input  logic [REM_BITS-1:0] den,
  input  logic [TAG_BITS-1:0] tag_in,
  output logic                out_valid,
  output logic [Q_BITS-1:0]   quot,
  output logic [REM_BITS-1:0] rem,
  output logic [TAG_BITS-1:0] tag_out
);

  logic                vld [Q_BITS];
  logic [REM_BITS-1:0] rr  [Q_BITS];
  logic [Q_BITS-1:0]   ww  [Q_BITS];
  logic [TAG_BITS-1:0] tg  [Q_BITS];

  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    logic                v_src;
    logic [REM_BITS-1:0] r_src;
    logic [Q_BITS-1:0]   w_src;
    logic [TAG_BITS-1:0] t_src;
    logic [REM_BITS:0]   trial;
    logic [REM_BITS:0]   diff;
    logic                ge;

    if (s == 0) begin : g_first
      assign v_src = in_valid;
      assign r_src = rem_init;
      assign w_src = num;
      assign t_src = tag_in;
    end else begin : g_next
      assign v_src = vld[s-1];
      assign r_src = rr[s-1];
      assign w_src = ww[s-1];
      assign t_src = tg[s-1];
    end

    assign trial = {r_src, w_src[Q_BITS-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[s] <= ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
        ww[s] <= {w_src[Q_BITS-2:0], ge};
        tg[s] <= t_src;
      end
    end
  end

  assign out_valid = vld[Q_BITS-1];
  assign quot      = ww[Q_BITS-1];
  assign rem       = rr[Q_BITS-1];
  assign tag_out   = tg[Q_BITS-1];

endmodule

[hdl/lwg_cfg.sv]
module lwg_cfg #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 24,
  parameter int DATA_BITS  = 32,
  parameter int ADDR_BITS  = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   cfg_ready,
  output lwg_pkg::geo_flags_t    flags,
  output logic [COORD_BITS-1:0]  org_x,
  output logic [COORD_BITS-1:0]  org_y,
  output logic [COORD_BITS-1:0]  lng,
  output logic [COORD_BITS-1:0]  sht,
  output logic [COORD_BITS:0]    na,
  output logic [COORD_BITS:0]    na_m1,
  output logic [COORD_BITS:0]    nl,
  output logic [COORD_BITS:0]    nl_m1,
  output logic [INDEX_BITS-1:0]  count
);

  localparam int CB   = COORD_BITS;
  localparam int NW   = COORD_BITS + 1;
  localparam int AST  = (DATA_BITS == 64) ? 3 : 2;
  localparam int PW   = (2 * NW > INDEX_BITS + 1) ? 2 * NW : INDEX_BITS + 1;
  localparam int CW   = $clog2(NW);

  logic [ADDR_BITS-AST-1:0] reg_sel;
  logic                     wr;

  logic [CB-1:0] start_x;
  logic [CB-1:0] start_y;
  logic [CB-1:0] end_x;
  logic [CB-1:0] end_y;
  logic [CB-2:0] lane_width;
  logic [CB-2:0] point_spacing;

  lwg_pkg::cfg_state_t state;
  lwg_pkg::cfg_state_t state_next;
  logic [CW-1:0]       cnt;

  logic [CB:0]   dxs;
  logic [CB:0]   dys;
  logic [CB-1:0] dx;
  logic [CB-1:0] dy;
  logic          x_up_c;
  logic          y_up_c;
  logic          flip_c;
  logic [CB-2:0] ps_eff;
  logic [CB-2:0] lw_eff;

  logic [CB-1:0] dq_a;
  logic [CB-1:0] dr_a;
  logic [CB-1:0] dq_b;
  logic [CB-1:0] dr_b;
  logic [CB:0]   trial_a;
  logic [CB:0]   trial_b;
  logic          ge_a;
  logic          ge_b;

  logic [NW-1:0] na_v;
  logic [NW-1:0] nl_t;
  logic [NW-1:0] nl_v;

  logic [PW-1:0] acc;
  logic [PW-1:0] mcand;
  logic [NW-1:0] mplier;

  assign reg_sel = paddr[ADDR_BITS-1:AST];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= '0;
      start_y       <= '0;
      end_x         <= '0;
      end_y         <= '0;
      lane_width    <= (CB-1)'(256);
      point_spacing <= (CB-1)'(256);
    end else if (wr) begin
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_START_X)) begin
        start_x <= pwdata[CB-1:0];
      end
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_START_Y)) begin
        start_y <= pwdata[CB-1:0];
      end
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_END_X)) begin
        end_x <= pwdata[CB-1:0];
      end
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_END_Y)) begin
        end_y <= pwdata[CB-1:0];
      end
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_LANE_WIDTH)) begin
        lane_width <= pwdata[CB-2:0];
      end
      if (reg_sel == (ADDR_BITS-AST)'(lwg_pkg::REG_POINT_SPACING)) begin
        point_spacing <= pwdata[CB-2:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      (ADDR_BITS-AST)'(lwg_pkg::REG_START_X):       prdata = DATA_BITS'(start_x);
      (ADDR_BITS-AST)'(lwg_pkg::REG_START_Y):       prdata = DATA_BITS'(start_y);
      (ADDR_BITS-AST)'(lwg_pkg::REG_END_X):         prdata = DATA_BITS'(end_x);
      (ADDR_BITS-AST)'(lwg_pkg::REG_END_Y):         prdata = DATA_BITS'(end_y);
      (ADDR_BITS-AST)'(lwg_pkg::REG_LANE_WIDTH):    prdata = DATA_BITS'(lane_width);
      (ADDR_BITS-AST)'(lwg_pkg::REG_POINT_SPACING): prdata = DATA_BITS'(point_spacing);
      default:                                      prdata = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    if (wr) begin
      state_next = lwg_pkg::CFG_LOAD;
    end else begin
      unique case (state)
        lwg_pkg::CFG_IDLE: state_next = lwg_pkg::CFG_IDLE;
        lwg_pkg::CFG_LOAD: state_next = lwg_pkg::CFG_DIV;
        lwg_pkg::CFG_DIV:  if (cnt == '0) state_next = lwg_pkg::CFG_SIZE;
        lwg_pkg::CFG_SIZE: state_next = lwg_pkg::CFG_MUL;
        lwg_pkg::CFG_MUL:  if (cnt == '0) state_next = lwg_pkg::CFG_IDLE;
        default:           state_next = lwg_pkg::CFG_IDLE;
      endcase
    end
  end

  always_comb begin
    cfg_ready = (state == lwg_pkg::CFG_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwg_pkg::CFG_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    dxs    = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
    dys    = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
    x_up_c = ~dxs[CB];
    y_up_c = ~dys[CB];
    dx     = x_up_c ? dxs[CB-1:0] : CB'(-dxs);
    dy     = y_up_c ? dys[CB-1:0] : CB'(-dys);
    flip_c = dx < dy;
    ps_eff = (point_spacing == '0) ? (CB-1)'(1) : point_spacing;
    lw_eff = (lane_width == '0) ? (CB-1)'(1) : lane_width;

    trial_a = {dr_a, dq_a[CB-1]};
    trial_b = {dr_b, dq_b[CB-1]};
    ge_a    = trial_a >= (CB+1)'(ps_eff);
    ge_b    = trial_b >= (CB+1)'(lw_eff);

    na_v = NW'(dq_a) + NW'(dr_a != '0) + NW'(1);
    nl_t = NW'(dq_b) + NW'(dr_b != '0) + NW'(1);
    nl_v = nl_t[0] ? nl_t : nl_t + NW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (state)
        lwg_pkg::CFG_LOAD: cnt <= CW'(CB - 1);
        lwg_pkg::CFG_DIV:  cnt <= (cnt == '0) ? CW'(NW - 1) : cnt - CW'(1);
        lwg_pkg::CFG_SIZE: cnt <= CW'(NW - 1);
        lwg_pkg::CFG_MUL:  cnt <= cnt - CW'(1);
        default:           cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lwg_pkg::CFG_LOAD: begin
        org_x      <= start_x;
        org_y      <= start_y;
        flags.flip <= flip_c;
        flags.x_up <= x_up_c;
        flags.y_up <= y_up_c;
        lng        <= flip_c ? dy : dx;
        sht        <= flip_c ? dx : dy;
        dq_a       <= flip_c ? dy : dx;
        dq_b       <= flip_c ? dx : dy;
        dr_a       <= '0;
        dr_b       <= '0;
      end
      lwg_pkg::CFG_DIV: begin
        dr_a <= ge_a ? CB'(trial_a - (CB+1)'(ps_eff)) : trial_a[CB-1:0];
        dr_b <= ge_b ? CB'(trial_b - (CB+1)'(lw_eff)) : trial_b[CB-1:0];
        dq_a <= {dq_a[CB-2:0], ge_a};
        dq_b <= {dq_b[CB-2:0], ge_b};
      end
      lwg_pkg::CFG_SIZE: begin
        na           <= na_v;
        na_m1        <= na_v - NW'(1);
        nl           <= nl_v;
        nl_m1        <= nl_v - NW'(1);
        flags.na_one <= (na_v == NW'(1));
        flags.nl_one <= (nl_v == NW'(1));
        mcand        <= PW'(na_v);
        mplier       <= nl_v;
        acc          <= '0;
      end
      lwg_pkg::CFG_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      default: begin
      end
    endcase
  end

  assign count = ((acc >> INDEX_BITS) != '0) ? '1 : acc[INDEX_BITS-1:0];

endmodule

[hdl/lawnmower_waypoint_generator.sv]
// Serpentine coverage path: answers a waypoint index with that point of the sweep.
// Configuration goes through the APB-style port (start and end corners, lane width,
// point spacing). After each register write, and after reset, the block recomputes
// the lane and point counts with a shared divide and multiply sequencer, and
// query_ready stays low meanwhile.
// Queries enter on query_valid/query_ready, one word per cycle when the receiver
// keeps up. Results leave on result_valid/result_ready in query order.
// The pipeline runs through the index divider, the lane check and column fold,
// the products, the two parallel offset dividers, and the output register.
// Throughput is one word per cycle. When result_ready is low with a result waiting,
// the whole pipeline holds and query_ready drops; no word is lost or repeated.
// Reset empties the pipeline and loads the register defaults.
module lawnmower_waypoint_generator #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 24,
  localparam int DATA_BITS = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS = (COORD_BITS > 32) ? 6 : 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready,
  input  logic                         query_valid,
  output logic                         query_ready,
  input  logic [INDEX_BITS-1:0]        point_index,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [COORD_BITS-1:0] x_pos,
  output logic signed [COORD_BITS-1:0] y_pos,
  output logic                         point_valid,
  output logic [INDEX_BITS-1:0]        point_count
);

  localparam int CB = COORD_BITS;
  localparam int IB = INDEX_BITS;
  localparam int NW = COORD_BITS + 1;
  localparam int MW = NW + IB;

  lwg_pkg::geo_flags_t flags;
  logic                cfg_ready;
  logic [CB-1:0]       org_x;
  logic [CB-1:0]       org_y;
  logic [CB-1:0]       lng;
  logic [CB-1:0]       sht;
  logic [NW-1:0]       na;
  logic [NW-1:0]       na_m1;
  logic [NW-1:0]       nl;
  logic [NW-1:0]       nl_m1;
  logic [IB-1:0]       count;

  logic                en;
  logic                take;
  logic                wr;

  logic                d1_valid;
  logic [IB-1:0]       d1_lane;
  logic [NW-1:0]       d1_col;

  logic                a_valid;
  logic                a_ok;
  logic [IB-1:0]       a_lane;
  logic [IB-1:0]       a_c;

  logic                b_valid;
  logic                b_ok;
  logic [IB+CB-1:0]    prod_a;
  logic [IB+CB-1:0]    prod_l;

  logic                d2_valid;
  logic                d2_ok;
  logic [CB-1:0]       qa;
  logic [CB-1:0]       ql;

  logic [CB-1:0]       offa;
  logic [CB-1:0]       offl;
  logic [CB-1:0]       x_off;
  logic [CB-1:0]       y_off;
  logic [CB-1:0]       x_new;
  logic [CB-1:0]       y_new;

  assign pready      = 1'b1;
  assign wr          = psel & penable & pwrite;
  assign en          = ~result_valid | result_ready;
  assign query_ready = en & cfg_ready & ~wr;
  assign take        = query_valid & query_ready;

  lwg_cfg #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS),
    .DATA_BITS  (DATA_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cfg_ready (cfg_ready),
    .flags     (flags),
    .org_x     (org_x),
    .org_y     (org_y),
    .lng       (lng),
    .sht       (sht),
    .na        (na),
    .na_m1     (na_m1),
    .nl        (nl),
    .nl_m1     (nl_m1),
    .count     (count)
  );

  lwg_div #(
    .REM_BITS (NW),
    .Q_BITS   (IB),
    .TAG_BITS (1)
  ) u_div_idx (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (take),
    .rem_init  ('0),
    .num       (point_index),
    .den       (na),
    .tag_in    (1'b0),
    .out_valid (d1_valid),
    .quot      (d1_lane),
    .rem       (d1_col),
    .tag_out   ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= d1_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ok   <= MW'(d1_lane) < MW'(nl);
      a_lane <= d1_lane;
      a_c    <= d1_lane[0] ? IB'(na_m1 - d1_col) : IB'(d1_col);
      b_ok   <= a_ok;
      prod_a <= (IB+CB)'(a_c) * (IB+CB)'(lng);
      prod_l <= (IB+CB)'(a_lane) * (IB+CB)'(sht);
    end
  end

  lwg_div #(
    .REM_BITS (NW),
    .Q_BITS   (CB),
    .TAG_BITS (1)
  ) u_div_along (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .rem_init  (NW'(prod_a >> CB)),
    .num       (prod_a[CB-1:0]),
    .den       (na_m1),
    .tag_in    (b_ok),
    .out_valid (d2_valid),
    .quot      (qa),
    .rem       (),
    .tag_out   (d2_ok)
  );

  lwg_div #(
    .REM_BITS (NW),
    .Q_BITS   (CB),
    .TAG_BITS (1)
  ) u_div_lane (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .rem_init  (NW'(prod_l >> CB)),
    .num       (prod_l[CB-1:0]),
    .den       (nl_m1),
    .tag_in    (1'b0),
    .out_valid (),
    .quot      (ql),
    .rem       (),
    .tag_out   ()
  );

  always_comb begin
    offa  = flags.na_one ? '0 : qa;
    offl  = flags.nl_one ? '0 : ql;
    x_off = flags.flip ? offl : offa;
    y_off = flags.flip ? offa : offl;
    x_new = flags.x_up ? org_x + x_off : org_x - x_off;
    y_new = flags.y_up ? org_y + y_off : org_y - y_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_pos       <= d2_ok ? x_new : '0;
      y_pos       <= d2_ok ? y_new : '0;
      point_valid <= d2_ok;
      point_count <= count;
    end
  end

endmodule
